// File: sv/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and helpers for the substring occurrence counter.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 64;
    localparam int NUM_WORDS       = 4;
    localparam int PATTERN_W       = WORD_W * NUM_WORDS;
    localparam int LEN_W           = 6;
    localparam int COUNT_W         = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 40;
    localparam int M_PAD_W         = M_TDATA_W - COUNT_W - 1;

    localparam logic [BYTE_W-1:0]  CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0]  CASE_OFFSET  = 8'h20;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_WORD_0 = 3'd0,
        REG_PATTERN_WORD_1 = 3'd1,
        REG_PATTERN_WORD_2 = 3'd2,
        REG_PATTERN_WORD_3 = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_IGNORE_CASE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [LEN_W-1:0]     length;
        logic                 ignore_case;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                    input logic ic);
        if (ic && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/substring_occurrence_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// substring_occurrence_counter
// Counts leftmost non-overlapping occurrences of a 1..MAX_PATTERN byte
// pattern in a byte stream, one result beat per text beat.
// ----------------------------------------------------------------------------
// Takes one text byte per clock and returns one result beat per byte;
// throughput is one beat per cycle while the output is taken. The byte
// sits in an input register, the window compare and the line and count
// update run while it is held there, and the result lands in an output
// register that holds while m_tready is low, so the input keeps flowing as
// long as the output register is taken. Matches restart after a newline, a
// zero byte hides the rest of its line, and the saturating count clears
// after the beat flagged with s_tlast. Write configuration only while idle.
module substring_occurrence_counter import ssc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] text_byte
    input  wire logic                   s_tlast,   // end_of_file
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata,   // [0] match_found, [32:1] running_count
    output logic                        m_tlast    // file_done
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int WIN_W = BYTE_W * MAX_PATTERN;

    cfg_t cfg_reg, cfg_next;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eof_reg;

    logic [WIN_W-1:0]   hist_reg, hist_next;
    logic [CNT_W-1:0]   line_reg, line_next;
    logic [CNT_W-1:0]   since_reg, since_next;
    logic               hidden_reg, hidden_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_match_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    logic               advance;
    logic [WIN_W+BYTE_W-1:0] window_full;
    logic [WIN_W-1:0]   window;
    logic [CNT_W-1:0]   line_inc;
    logic [CNT_W-1:0]   since_inc;
    logic               hidden_cur;
    logic               hit;
    logic [COUNT_W-1:0] total_cur;
    logic               line_end;

    // configuration
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_WORD_0: cfg_next.pattern[0*WORD_W +: WORD_W] = cfg_wdata;
                REG_PATTERN_WORD_1: cfg_next.pattern[1*WORD_W +: WORD_W] = cfg_wdata;
                REG_PATTERN_WORD_2: cfg_next.pattern[2*WORD_W +: WORD_W] = cfg_wdata;
                REG_PATTERN_WORD_3: cfg_next.pattern[3*WORD_W +: WORD_W] = cfg_wdata;
                REG_PATTERN_LENGTH: cfg_next.length = cfg_wdata[LEN_W-1:0];
                REG_IGNORE_CASE:    cfg_next.ignore_case = cfg_wdata[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern     <= '0;
            cfg_reg.length      <= LEN_W'(1);
            cfg_reg.ignore_case <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // per-byte update
    assign window_full = {hist_reg, in_byte_reg};
    assign window      = window_full[WIN_W-1:0];
    assign hidden_cur  = hidden_reg || (in_byte_reg == CHAR_NUL);
    assign line_inc    = (line_reg < CNT_W'(MAX_PATTERN)) ? line_reg + CNT_W'(1) : line_reg;
    assign since_inc   = (since_reg < CNT_W'(MAX_PATTERN)) ? since_reg + CNT_W'(1) : since_reg;
    assign line_end    = (in_byte_reg == CHAR_NEWLINE) || in_eof_reg;

    ssc_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_match (
        .cfg       (cfg_reg),
        .window    (window),
        .line_cnt  (line_inc),
        .since_cnt (since_inc),
        .hidden    (hidden_cur),
        .hit       (hit)
    );

    assign total_cur = (hit && (total_reg != COUNT_MAX)) ? total_reg + COUNT_W'(1) : total_reg;

    always_comb begin
        hist_next   = window;
        line_next   = line_inc;
        since_next  = hit ? '0 : since_inc;
        hidden_next = hidden_cur;
        total_next  = in_eof_reg ? '0 : total_cur;
        if (line_end) begin
            line_next   = '0;
            since_next  = CNT_W'(MAX_PATTERN);
            hidden_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            since_reg     <= CNT_W'(MAX_PATTERN);
            hidden_reg    <= 1'b0;
            total_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                line_reg   <= line_next;
                since_reg  <= since_next;
                hidden_reg <= hidden_next;
                total_reg  <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            in_eof_reg  <= s_tlast;
        end
        if (advance) begin
            hist_reg      <= hist_next;
            out_match_reg <= hit;
            out_count_reg <= total_cur;
            out_last_reg  <= in_eof_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_count_reg, out_match_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: sv/ssc_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_match
// Window compare and match qualification for one text byte.
// ----------------------------------------------------------------------------
module ssc_match import ssc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
    input  wire cfg_t                        cfg,
    input  wire logic [BYTE_W*MAX_PATTERN-1:0] window,
    input  wire logic [CNT_W-1:0]            line_cnt,
    input  wire logic [CNT_W-1:0]            since_cnt,
    input  wire logic                        hidden,
    output logic                             hit
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CNT_W-1:0]  len_eff;
    logic [BYTE_W-1:0] pat_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;

    always_comb begin
        if (cfg.length > LEN_W'(MAX_PATTERN)) begin
            len_eff = CNT_W'(MAX_PATTERN);
        end else begin
            len_eff = CNT_W'(cfg.length);
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pat_bytes[k] = cfg.pattern[BYTE_W*k +: BYTE_W];
        end
    end

    // window byte j lines up with pattern byte len-1-j
    always_comb begin
        logic [CNT_W-1:0]  pidx;
        logic [BYTE_W-1:0] tb;
        logic [BYTE_W-1:0] pb;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pidx = len_eff - CNT_W'(1) - CNT_W'(j);
            tb = fold_byte(window[BYTE_W*j +: BYTE_W], cfg.ignore_case);
            pb = fold_byte(pat_bytes[pidx[IDX_W-1:0]], cfg.ignore_case);
            pos_ok[j] = (CNT_W'(j) >= len_eff) || (tb == pb);
        end
    end

    assign hit = (cfg.length != '0) && !hidden && (line_cnt >= len_eff)
               && (since_cnt >= len_eff) && (&pos_ok);

endmodule
`default_nettype wire

// File: sv/ssc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the result stream of the substring occurrence counter.
// ----------------------------------------------------------------------------
module ssc_checker import ssc_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    logic               beat;
    logic               match;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] prev_reg;

    assign beat  = m_tvalid && m_tready;
    assign match = m_tdata[0];
    assign count = m_tdata[COUNT_W:1];

    // count seen on the previous beat of this file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (beat) begin
            prev_reg <= m_tlast ? '0 : count;
        end
    end

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && match && (prev_reg != COUNT_MAX) |-> count == prev_reg + COUNT_W'(1))
        else $error("count did not step on match");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && (!match || (prev_reg == COUNT_MAX)) |-> count == prev_reg)
        else $error("count changed without match");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind substring_occurrence_counter ssc_checker u_ssc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
